/* rtl/core/touch_contact_report_builder_defines.svh */
// ----------------------------------------------------------------------------
// Touch contact report builder assertion macros
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CONTACT_REPORT_BUILDER_DEFINES_SVH
`define TOUCH_CONTACT_REPORT_BUILDER_DEFINES_SVH

// Check a property while out of reset.
`define TCRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TCRB_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tcrb_pkg.sv */
// ----------------------------------------------------------------------------
// Touch contact report builder package
// Sizes, opcodes, command and state types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrb_pkg;

  localparam int MAX_CONTACTS = 5;
  localparam int SLOT_W       = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int OPC_W        = 3;
  localparam int IN_SLOT_W    = 8;
  localparam int COORD_W      = 16;
  localparam int ID_W         = 5;
  localparam int BYTE_W       = 8;
  localparam int FIFO_DEPTH   = 2;

  localparam logic [BYTE_W-1:0] REPORT_ID_RST = 8'd1;

  localparam logic [OPC_W-1:0] OP_DOWN        = 3'd0;
  localparam logic [OPC_W-1:0] OP_MOVE        = 3'd1;
  localparam logic [OPC_W-1:0] OP_UP          = 3'd2;
  localparam logic [OPC_W-1:0] OP_RELEASE_ALL = 3'd3;
  localparam logic [OPC_W-1:0] OP_FLUSH       = 3'd4;

  typedef enum logic [2:0] {
    CMD_DOWN,
    CMD_MOVE,
    CMD_UP,
    CMD_RELALL,
    CMD_FLUSH,
    CMD_REFUSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic not_empty;
    cmd_t cmd;
  } q_rd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SLOTS,
    BK_TAIL
  } back_state_t;

  typedef enum logic [2:0] {
    FLD_STATUS,
    FLD_X_LO,
    FLD_X_HI,
    FLD_Y_LO,
    FLD_Y_HI
  } field_t;

endpackage

`default_nettype wire

/* rtl/core/tcrb_in_if.sv */
// ----------------------------------------------------------------------------
// Touch contact command channel
// Valid/ready channel carrying one touch operation per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcrb_in_if;
  logic                               valid;
  logic                               ready;
  logic [tcrb_pkg::OPC_W-1:0]         opcode;
  logic [tcrb_pkg::IN_SLOT_W-1:0]     contact_slot;
  logic [tcrb_pkg::COORD_W-1:0]       x_coord;
  logic [tcrb_pkg::COORD_W-1:0]       y_coord;

  modport source (output valid, opcode, contact_slot, x_coord, y_coord, input ready);
  modport sink   (input valid, opcode, contact_slot, x_coord, y_coord, output ready);
endinterface

`default_nettype wire

/* rtl/core/tcrb_out_if.sv */
// ----------------------------------------------------------------------------
// Touch contact result channel
// Valid/ready channel carrying one result or report byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcrb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          byte_valid;
  logic [tcrb_pkg::BYTE_W-1:0]   report_byte;
  logic                          last_byte;

  modport source (output valid, accepted, byte_valid, report_byte, last_byte, input ready);
  modport sink   (input valid, accepted, byte_valid, report_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/tcrb_front.sv */
// ----------------------------------------------------------------------------
// Touch contact front end
// Accepts command beats, checks slot range and opcode, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrb_front (
  tcrb_in_if.sink           in_ch,
  input  wire logic         q_full,
  output tcrb_pkg::q_wr_t   q_wr
);

  logic in_range;

  assign in_range    = in_ch.contact_slot < tcrb_pkg::IN_SLOT_W'(tcrb_pkg::MAX_CONTACTS);
  assign in_ch.ready = !q_full;

  always_comb begin
    q_wr.push     = in_ch.valid && !q_full;
    q_wr.cmd.slot = in_ch.contact_slot[tcrb_pkg::SLOT_W-1:0];
    q_wr.cmd.x    = in_ch.x_coord;
    q_wr.cmd.y    = in_ch.y_coord;
    unique case (in_ch.opcode)
      tcrb_pkg::OP_DOWN:        q_wr.cmd.kind = in_range ? tcrb_pkg::CMD_DOWN
                                                         : tcrb_pkg::CMD_REFUSE;
      tcrb_pkg::OP_MOVE:        q_wr.cmd.kind = in_range ? tcrb_pkg::CMD_MOVE
                                                         : tcrb_pkg::CMD_REFUSE;
      tcrb_pkg::OP_UP:          q_wr.cmd.kind = in_range ? tcrb_pkg::CMD_UP
                                                         : tcrb_pkg::CMD_REFUSE;
      tcrb_pkg::OP_RELEASE_ALL: q_wr.cmd.kind = tcrb_pkg::CMD_RELALL;
      tcrb_pkg::OP_FLUSH:       q_wr.cmd.kind = tcrb_pkg::CMD_FLUSH;
      default:                  q_wr.cmd.kind = tcrb_pkg::CMD_REFUSE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/tcrb_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Touch contact command queue
// Short first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrb_cmd_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tcrb_pkg::q_wr_t  q_wr,
  input  wire logic             pop,
  output logic                  full,
  output tcrb_pkg::q_rd_t       q_rd
);

  localparam int PTR_W = (tcrb_pkg::FIFO_DEPTH > 1) ? $clog2(tcrb_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcrb_pkg::FIFO_DEPTH + 1);

  tcrb_pkg::cmd_t    mem_r [tcrb_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full           = cnt_r == CNT_W'(tcrb_pkg::FIFO_DEPTH);
  assign q_rd.not_empty = cnt_r != '0;
  assign q_rd.cmd       = mem_r[rd_ptr_r];
  assign do_push        = q_wr.push && !full;
  assign do_pop         = pop && q_rd.not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tcrb_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tcrb_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcrb_back.sv */
// ----------------------------------------------------------------------------
// Touch contact back end
// Holds the slot table, applies commands and serializes flushed reports.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrb_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tcrb_pkg::BYTE_W-1:0]   cfg_wr_data,
  input  wire tcrb_pkg::q_rd_t               q_rd,
  output logic                               pop,
  tcrb_out_if.source                         out_ch
);

  localparam int N = tcrb_pkg::MAX_CONTACTS;
  localparam int SW = tcrb_pkg::SLOT_W;

  tcrb_pkg::back_state_t             state_r, state_nxt;
  tcrb_pkg::field_t                  fld_r, fld_nxt;
  logic [SW-1:0]                     slot_cnt_r, slot_cnt_nxt;
  logic [tcrb_pkg::BYTE_W-1:0]       rpt_hdr_r;

  logic [N-1:0]                      active_r;
  logic [tcrb_pkg::ID_W-1:0]         id_r [N];
  logic [tcrb_pkg::COORD_W-1:0]      x_r  [N];
  logic [tcrb_pkg::COORD_W-1:0]      y_r  [N];

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_acc_r, out_acc_nxt;
  logic                              out_bv_r, out_bv_nxt;
  logic [tcrb_pkg::BYTE_W-1:0]       out_byte_r, out_byte_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              out_free, out_load;
  logic [SW-1:0]                     rd_idx;
  logic                              wr_pos, set_act, clr_act, clr_all;
  logic [tcrb_pkg::ID_W-1:0]         rd_id;
  logic [tcrb_pkg::COORD_W-1:0]      rd_x, rd_y;
  logic                              rd_act;

  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_idx   = (state_r == tcrb_pkg::BK_IDLE) ? q_rd.cmd.slot : slot_cnt_r;
  assign rd_act   = active_r[rd_idx];
  assign rd_id    = id_r[rd_idx];
  assign rd_x     = x_r[rd_idx];
  assign rd_y     = y_r[rd_idx];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.byte_valid  = out_bv_r;
  assign out_ch.report_byte = out_byte_r;
  assign out_ch.last_byte   = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    fld_nxt      = fld_r;
    slot_cnt_nxt = slot_cnt_r;
    pop          = 1'b0;
    out_load     = 1'b0;
    out_acc_nxt  = out_acc_r;
    out_bv_nxt   = out_bv_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    wr_pos       = 1'b0;
    set_act      = 1'b0;
    clr_act      = 1'b0;
    clr_all      = 1'b0;
    unique case (state_r)
      tcrb_pkg::BK_IDLE: begin
        if (q_rd.not_empty && out_free) begin
          pop          = 1'b1;
          out_load     = 1'b1;
          out_acc_nxt  = 1'b0;
          out_bv_nxt   = 1'b0;
          out_byte_nxt = '0;
          out_last_nxt = 1'b1;
          unique case (q_rd.cmd.kind)
            tcrb_pkg::CMD_FLUSH: begin
              out_acc_nxt  = 1'b1;
              out_bv_nxt   = 1'b1;
              out_byte_nxt = rpt_hdr_r;
              out_last_nxt = 1'b0;
              slot_cnt_nxt = '0;
              fld_nxt      = tcrb_pkg::FLD_STATUS;
              state_nxt    = tcrb_pkg::BK_SLOTS;
            end
            tcrb_pkg::CMD_DOWN: begin
              wr_pos      = 1'b1;
              set_act     = 1'b1;
              out_acc_nxt = 1'b1;
            end
            tcrb_pkg::CMD_MOVE: begin
              wr_pos      = rd_act;
              out_acc_nxt = rd_act;
            end
            tcrb_pkg::CMD_UP: begin
              clr_act     = 1'b1;
              out_acc_nxt = 1'b1;
            end
            tcrb_pkg::CMD_RELALL: begin
              clr_all     = 1'b1;
              out_acc_nxt = 1'b1;
            end
            default: out_acc_nxt = 1'b0;
          endcase
        end
      end
      tcrb_pkg::BK_SLOTS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_acc_nxt  = 1'b1;
          out_bv_nxt   = 1'b1;
          out_last_nxt = 1'b0;
          unique case (fld_r)
            tcrb_pkg::FLD_STATUS: out_byte_nxt = {rd_id, 2'b00, rd_act};
            tcrb_pkg::FLD_X_LO:   out_byte_nxt = rd_x[7:0];
            tcrb_pkg::FLD_X_HI:   out_byte_nxt = rd_x[15:8];
            tcrb_pkg::FLD_Y_LO:   out_byte_nxt = rd_y[7:0];
            default:              out_byte_nxt = rd_y[15:8];
          endcase
          if (fld_r == tcrb_pkg::FLD_Y_HI) begin
            fld_nxt = tcrb_pkg::FLD_STATUS;
            if (slot_cnt_r == SW'(N - 1)) begin
              state_nxt = tcrb_pkg::BK_TAIL;
            end else begin
              slot_cnt_nxt = slot_cnt_r + 1'b1;
            end
          end else begin
            fld_nxt = tcrb_pkg::field_t'(fld_r + 3'd1);
          end
        end
      end
      tcrb_pkg::BK_TAIL: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_acc_nxt  = 1'b1;
          out_bv_nxt   = 1'b1;
          out_byte_nxt = tcrb_pkg::BYTE_W'($countones(active_r));
          out_last_nxt = 1'b1;
          state_nxt    = tcrb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tcrb_pkg::BK_IDLE;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcrb_pkg::BK_IDLE;
      fld_r       <= tcrb_pkg::FLD_STATUS;
      slot_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      rpt_hdr_r   <= tcrb_pkg::REPORT_ID_RST;
    end else begin
      state_r     <= state_nxt;
      fld_r       <= fld_nxt;
      slot_cnt_r  <= slot_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        rpt_hdr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r  <= out_acc_nxt;
    out_bv_r   <= out_bv_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int i = 0; i < N; i++) begin
        id_r[i] <= '0;
        x_r[i]  <= '0;
        y_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < N; i++) begin
        if (clr_all) begin
          active_r[i] <= 1'b0;
        end else if (q_rd.cmd.slot == SW'(i)) begin
          if (set_act) begin
            active_r[i] <= 1'b1;
            id_r[i]     <= tcrb_pkg::ID_W'(q_rd.cmd.slot);
          end else if (clr_act) begin
            active_r[i] <= 1'b0;
          end
          if (wr_pos) begin
            x_r[i] <= q_rd.cmd.x;
            y_r[i] <= q_rd.cmd.y;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/touch_contact_report_builder.sv */
// ----------------------------------------------------------------------------
// Touch contact report builder
// Multitouch contact table with a byte-serial digitizer report on flush.
//
//   channel   dir  beat
//   in_ch     in   opcode, contact_slot, x_coord, y_coord
//   out_ch    out  accepted, byte_valid, report_byte, last_byte
//   cfg_*     in   report id byte, written when cfg_wr_en is high
//
// Down, move, up and release-all each give one beat; with the two-entry queue
// a command can be taken every cycle unless results stall or a flush runs.
// Flush gives 2 + 5 * MAX_CONTACTS beats from the back-end byte sequencer,
// one per cycle while ready is high; the queue takes commands until full.
// Reset is synchronous and clears the table, queue and result valid flag. A
// stalled result holds in the output register; the queue fills behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_contact_report_builder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tcrb_in_if.sink                            in_ch,
  tcrb_out_if.source                         out_ch,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tcrb_pkg::BYTE_W-1:0]   cfg_wr_data
);

  tcrb_pkg::q_wr_t  q_wr;
  tcrb_pkg::q_rd_t  q_rd;
  logic             q_full;
  logic             q_pop;

  tcrb_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  tcrb_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  tcrb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_rd        (q_rd),
    .pop         (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/core/tcrb_checker.sv */
// ----------------------------------------------------------------------------
// Touch contact report builder checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "touch_contact_report_builder_defines.svh"

module tcrb_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_accepted,
  input wire logic                          out_byte_valid,
  input wire logic [tcrb_pkg::BYTE_W-1:0]   out_report_byte,
  input wire logic                          out_last_byte
);

  `TCRB_ASSERT_NR(a_rst_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `TCRB_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_report_byte) && $stable(out_last_byte) && $stable(out_byte_valid) && $stable(out_accepted), "stalled result beat changed")
  `TCRB_ASSERT(a_update_beat, clk, rst_n, out_valid && !out_byte_valid |-> out_last_byte && (out_report_byte == '0), "update result not a single zero beat")
  `TCRB_ASSERT(a_report_acc, clk, rst_n, out_valid && out_byte_valid |-> out_accepted, "report byte not marked accepted")

endmodule

bind touch_contact_report_builder tcrb_checker u_tcrb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_accepted    (out_ch.accepted),
  .out_byte_valid  (out_ch.byte_valid),
  .out_report_byte (out_ch.report_byte),
  .out_last_byte   (out_ch.last_byte)
);

`default_nettype wire

/* dv/tb_touch_contact_report_builder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch contact report builder testbench
// Drives touch commands and report flushes over the command channel with
// random gaps and result stalls, predicts result beats from a local copy
// of the contact table and report id, and compares each beat field by field.
// ----------------------------------------------------------------------------

module tb_touch_contact_report_builder;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 345;
  localparam int CALM_TAIL    = 60;
  localparam int TAIL_CYCLES  = 40;

  localparam logic [tcrb_pkg::OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [tcrb_pkg::OPC_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic TYPED   = 1'b1;
  localparam logic PREDICT = 1'b0;

  typedef struct packed {
    logic                           accepted;
    logic                           byte_valid;
    logic [tcrb_pkg::BYTE_W-1:0]    report_byte;
    logic                           last_byte;
  } result_beat_t;

  typedef struct packed {
    logic [tcrb_pkg::OPC_W-1:0]      op;
    logic [tcrb_pkg::IN_SLOT_W-1:0]  slot;
    logic [tcrb_pkg::COORD_W-1:0]    x;
    logic [tcrb_pkg::COORD_W-1:0]    y;
    logic                            typed;
    logic                            acc;
  } stim_row_t;

  localparam int N_DIRECTED = 23;
  localparam logic [7:0] LAST_SLOT = 8'(tcrb_pkg::MAX_CONTACTS - 1);
  localparam logic [7:0] OVER_SLOT = 8'(tcrb_pkg::MAX_CONTACTS);

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{tcrb_pkg::OP_FLUSH,       8'd0,      16'h0000, 16'h0000, PREDICT, 1'b0},
    '{tcrb_pkg::OP_MOVE,        8'd0,      16'h0001, 16'h0001, TYPED,   1'b0},
    '{tcrb_pkg::OP_UP,          8'd0,      16'h0000, 16'h0000, TYPED,   1'b1},
    '{tcrb_pkg::OP_DOWN,        8'd0,      16'h0000, 16'h0000, TYPED,   1'b1},
    '{tcrb_pkg::OP_DOWN,        LAST_SLOT, 16'hFFFF, 16'hFFFF, TYPED,   1'b1},
    '{tcrb_pkg::OP_DOWN,        OVER_SLOT, 16'h1234, 16'h5678, TYPED,   1'b0},
    '{tcrb_pkg::OP_DOWN,        8'hFF,     16'hFFFF, 16'hFFFF, TYPED,   1'b0},
    '{tcrb_pkg::OP_MOVE,        LAST_SLOT, 16'h1234, 16'hABCD, PREDICT, 1'b0},
    '{tcrb_pkg::OP_MOVE,        8'hFF,     16'h0000, 16'h0000, TYPED,   1'b0},
    '{tcrb_pkg::OP_UP,          8'hFF,     16'h0000, 16'h0000, TYPED,   1'b0},
    '{OP_SPARE_LO,              8'd0,      16'hFFFF, 16'hFFFF, TYPED,   1'b0},
    '{OP_SPARE_HI,              8'hFF,     16'h0000, 16'h0000, TYPED,   1'b0},
    '{tcrb_pkg::OP_DOWN,        8'd2,      16'h8000, 16'h00FF, TYPED,   1'b1},
    '{tcrb_pkg::OP_FLUSH,       8'd0,      16'h0000, 16'h0000, PREDICT, 1'b0},
    '{tcrb_pkg::OP_UP,          LAST_SLOT, 16'h0000, 16'h0000, TYPED,   1'b1},
    '{tcrb_pkg::OP_MOVE,        LAST_SLOT, 16'h4321, 16'h8765, TYPED,   1'b0},
    '{tcrb_pkg::OP_FLUSH,       8'hFF,     16'hFFFF, 16'hFFFF, PREDICT, 1'b0},
    '{tcrb_pkg::OP_DOWN,        8'd1,      16'h5A5A, 16'hA5A5, TYPED,   1'b1},
    '{tcrb_pkg::OP_DOWN,        8'd3,      16'hA5A5, 16'h5A5A, TYPED,   1'b1},
    '{tcrb_pkg::OP_MOVE,        8'd0,      16'hFFFF, 16'h0000, PREDICT, 1'b0},
    '{tcrb_pkg::OP_RELEASE_ALL, 8'hFF,     16'hFFFF, 16'hFFFF, TYPED,   1'b1},
    '{tcrb_pkg::OP_MOVE,        8'd1,      16'h0000, 16'h0000, TYPED,   1'b0},
    '{tcrb_pkg::OP_FLUSH,       8'hAA,     16'h0F0F, 16'hF0F0, PREDICT, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [tcrb_pkg::BYTE_W-1:0] cfg_wr_data;

  tcrb_in_if  in_ch ();
  tcrb_out_if out_ch ();

  touch_contact_report_builder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // contact table and report id as the block should hold them
  logic                          tbl_active [tcrb_pkg::MAX_CONTACTS];
  logic [tcrb_pkg::ID_W-1:0]     tbl_id     [tcrb_pkg::MAX_CONTACTS];
  logic [tcrb_pkg::COORD_W-1:0]  tbl_x      [tcrb_pkg::MAX_CONTACTS];
  logic [tcrb_pkg::COORD_W-1:0]  tbl_y      [tcrb_pkg::MAX_CONTACTS];
  logic [tcrb_pkg::BYTE_W-1:0]   rpt_hdr;

  result_beat_t pending_beats [$];
  result_beat_t want_beat;

  int  errors         = 0;
  int  cycle_count    = 0;
  int  beats_checked  = 0;
  int  commands_sent  = 0;
  int  flushes_sent   = 0;
  int  refusals_seen  = 0;
  int  id_settings    = 1;
  int  rx_stall_left  = 0;
  bit  idle_on        = 1'b1;

  function automatic result_beat_t make_beat(logic acc, logic bv,
                                             logic [tcrb_pkg::BYTE_W-1:0] b,
                                             logic last);
    result_beat_t beat;
    beat.accepted    = acc;
    beat.byte_valid  = bv;
    beat.report_byte = b;
    beat.last_byte   = last;
    return beat;
  endfunction

  // apply one command to the table and queue the beats it must produce
  function automatic void predict_touch_results(logic [tcrb_pkg::OPC_W-1:0] op,
                                                logic [tcrb_pkg::IN_SLOT_W-1:0] slot,
                                                logic [tcrb_pkg::COORD_W-1:0] x,
                                                logic [tcrb_pkg::COORD_W-1:0] y);
    int  count;
    bit  in_range;
    logic acc;
    count    = 0;
    in_range = (slot < tcrb_pkg::MAX_CONTACTS);
    acc      = 1'b0;
    if (op == tcrb_pkg::OP_FLUSH) begin
      pending_beats.push_back(make_beat(1'b1, 1'b1, rpt_hdr, 1'b0));
      for (int i = 0; i < tcrb_pkg::MAX_CONTACTS; i++) begin
        pending_beats.push_back(make_beat(1'b1, 1'b1, {tbl_id[i], 2'b00, tbl_active[i]}, 1'b0));
        pending_beats.push_back(make_beat(1'b1, 1'b1, tbl_x[i][7:0], 1'b0));
        pending_beats.push_back(make_beat(1'b1, 1'b1, tbl_x[i][15:8], 1'b0));
        pending_beats.push_back(make_beat(1'b1, 1'b1, tbl_y[i][7:0], 1'b0));
        pending_beats.push_back(make_beat(1'b1, 1'b1, tbl_y[i][15:8], 1'b0));
        if (tbl_active[i])
          count++;
      end
      pending_beats.push_back(make_beat(1'b1, 1'b1, 8'(count), 1'b1));
      return;
    end
    case (op)
      tcrb_pkg::OP_DOWN: begin
        if (in_range) begin
          tbl_active[slot] = 1'b1;
          tbl_id[slot]     = slot[tcrb_pkg::ID_W-1:0];
          tbl_x[slot]      = x;
          tbl_y[slot]      = y;
          acc              = 1'b1;
        end
      end
      tcrb_pkg::OP_MOVE: begin
        if (in_range && tbl_active[slot]) begin
          tbl_x[slot] = x;
          tbl_y[slot] = y;
          acc         = 1'b1;
        end
      end
      tcrb_pkg::OP_UP: begin
        if (in_range) begin
          tbl_active[slot] = 1'b0;
          acc              = 1'b1;
        end
      end
      tcrb_pkg::OP_RELEASE_ALL: begin
        for (int i = 0; i < tcrb_pkg::MAX_CONTACTS; i++)
          tbl_active[i] = 1'b0;
        acc = 1'b1;
      end
      default: acc = 1'b0;
    endcase
    pending_beats.push_back(make_beat(acc, 1'b0, '0, 1'b1));
  endfunction

  task automatic send_command(logic [tcrb_pkg::OPC_W-1:0] op,
                              logic [tcrb_pkg::IN_SLOT_W-1:0] slot,
                              logic [tcrb_pkg::COORD_W-1:0] x,
                              logic [tcrb_pkg::COORD_W-1:0] y,
                              logic typed, logic typed_acc);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.contact_slot <= slot;
    in_ch.x_coord      <= x;
    in_ch.y_coord      <= y;
    do @(posedge clk); while (!in_ch.ready);
    predict_touch_results(op, slot, x, y);
    if (typed) begin
      void'(pending_beats.pop_back());
      pending_beats.push_back(make_beat(typed_acc, 1'b0, '0, 1'b1));
    end
    commands_sent++;
    if (op == tcrb_pkg::OP_FLUSH)
      flushes_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic set_rpt_hdr(logic [tcrb_pkg::BYTE_W-1:0] value);
    hold_until_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    rpt_hdr = value;
    id_settings++;
  endtask

  function automatic logic [tcrb_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return tcrb_pkg::COORD_W'($urandom);
    endcase
  endfunction

  task automatic send_random_commands(int count, int calm_from);
    int r;
    logic [tcrb_pkg::OPC_W-1:0] op;
    logic [tcrb_pkg::IN_SLOT_W-1:0] slot;
    for (int n = 0; n < count; n++) begin
      idle_on = (n < calm_from) && ((n / 40) % 3 != 2);
      r    = $urandom_range(0, 99);
      slot = tcrb_pkg::IN_SLOT_W'($urandom_range(0, tcrb_pkg::MAX_CONTACTS - 1));
      if (r < 28)
        op = tcrb_pkg::OP_DOWN;
      else if (r < 55)
        op = tcrb_pkg::OP_MOVE;
      else if (r < 68)
        op = tcrb_pkg::OP_UP;
      else if (r < 72) begin
        op   = tcrb_pkg::OP_RELEASE_ALL;
        slot = tcrb_pkg::IN_SLOT_W'($urandom);
      end else if (r < 80) begin
        op   = tcrb_pkg::OP_FLUSH;
        slot = tcrb_pkg::IN_SLOT_W'($urandom);
      end else if (r < 92) begin
        op   = tcrb_pkg::OPC_W'($urandom_range(tcrb_pkg::OP_DOWN, tcrb_pkg::OP_UP));
        slot = tcrb_pkg::IN_SLOT_W'($urandom_range(tcrb_pkg::MAX_CONTACTS, 255));
      end else begin
        op   = tcrb_pkg::OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        slot = tcrb_pkg::IN_SLOT_W'($urandom);
      end
      send_command(op, slot, pick_coord(), pick_coord(), PREDICT, 1'b0);
    end
  endtask

  // result side: random stall bursts
  always @(negedge clk) begin
    if (rx_stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
      rx_stall_left = $urandom_range(1, 18);
    if (rx_stall_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(string field, int want, int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none actual acc=%0d bv=%0d byte=%0d last=%0d",
                 $time, out_ch.accepted, out_ch.byte_valid, out_ch.report_byte,
                 out_ch.last_byte);
      end else begin
        want_beat = pending_beats.pop_front();
        beats_checked++;
        if (!want_beat.accepted)
          refusals_seen++;
        if (out_ch.accepted !== want_beat.accepted)
          report_mismatch("accepted", want_beat.accepted, out_ch.accepted);
        if (out_ch.byte_valid !== want_beat.byte_valid)
          report_mismatch("byte_valid", want_beat.byte_valid, out_ch.byte_valid);
        if (out_ch.report_byte !== want_beat.report_byte)
          report_mismatch("report_byte", want_beat.report_byte, out_ch.report_byte);
        if (out_ch.last_byte !== want_beat.last_byte)
          report_mismatch("last_byte", want_beat.last_byte, out_ch.last_byte);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
      $display("tb_touch_contact_report_builder: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = tcrb_pkg::OP_DOWN;
    in_ch.contact_slot = '0;
    in_ch.x_coord      = '0;
    in_ch.y_coord      = '0;
    out_ch.ready       = 1'b0;
    rpt_hdr            = tcrb_pkg::REPORT_ID_RST;
    for (int i = 0; i < tcrb_pkg::MAX_CONTACTS; i++) begin
      tbl_active[i] = 1'b0;
      tbl_id[i]     = '0;
      tbl_x[i]      = '0;
      tbl_y[i]      = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_command(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].x,
                   directed_rows[i].y, directed_rows[i].typed, directed_rows[i].acc);

    set_rpt_hdr(8'hFF);
    send_command(tcrb_pkg::OP_FLUSH, 8'd0, 16'h0, 16'h0, PREDICT, 1'b0);
    send_random_commands(RANDOM_ITEMS / 3, RANDOM_ITEMS);

    set_rpt_hdr(8'h00);
    send_command(tcrb_pkg::OP_FLUSH, 8'd0, 16'h0, 16'h0, PREDICT, 1'b0);
    send_random_commands(RANDOM_ITEMS / 3, RANDOM_ITEMS);

    set_rpt_hdr(tcrb_pkg::BYTE_W'($urandom_range(2, 254)));
    send_random_commands(RANDOM_ITEMS / 3, RANDOM_ITEMS / 3 - CALM_TAIL);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d commands, %0d of them flushes, over %0d report id settings",
             commands_sent, flushes_sent, id_settings);
    $display("%0d result beats compared, %0d of them refusals", beats_checked, refusals_seen);
    if (errors == 0 && pending_beats.size() == 0)
      $display("tb_touch_contact_report_builder: done, clean");
    else
      $display("tb_touch_contact_report_builder: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tcrb_pkg.sv
rtl/core/tcrb_in_if.sv
rtl/core/tcrb_out_if.sv
rtl/core/tcrb_front.sv
rtl/core/tcrb_cmd_fifo.sv
rtl/core/tcrb_back.sv
rtl/core/touch_contact_report_builder.sv
rtl/core/tcrb_checker.sv
dv/tb_touch_contact_report_builder.sv
